// ----- hdl/drad_pkg.sv -----
// ----------------------------------------------------------------------------
// drad_pkg
// shared constants, types and hash tables of the rolling hash anchor detector
// ----------------------------------------------------------------------------
package drad_pkg;

    localparam int WINDOW = 32;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int ROT_W  = WINDOW % 64;

    localparam logic [63:0] SEED_ONE     = 64'h46a7c15d3b92e801;
    localparam logic [63:0] SEED_TWO     = 64'hd1b54a32d192ed03;
    localparam logic [63:0] MIX_STEP     = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_ONE  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_TWO  = 64'h94d049bb133111eb;
    localparam logic [63:0] MASK_RESET   = 64'd63;

    typedef logic [255:0][63:0] tab_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  old_byte;
        logic        start;
        logic        use_out;
        logic        full;
        logic [31:0] position;
    } s1_t;

    // splitmix64 sequence, evaluated at elaboration only
    function automatic tab_t build_table(logic [63:0] seed);
        logic [63:0] s;
        logic [63:0] z;
        tab_t        t;
        s = seed;
        for (int i = 0; i < 256; i++)
        begin
            s = s + MIX_STEP;
            z = s;
            z = (z ^ (z >> 30)) * MIX_MUL_ONE;
            z = (z ^ (z >> 27)) * MIX_MUL_TWO;
            t[i] = z ^ (z >> 31);
        end
        return t;
    endfunction

    localparam tab_t TAB_ONE = build_table(SEED_ONE);
    localparam tab_t TAB_TWO = build_table(SEED_TWO);

    function automatic logic [63:0] rotl_one(logic [63:0] v);
        return {v[62:0], v[63]};
    endfunction

    function automatic logic [63:0] rotl_window(logic [63:0] v);
        return (v << ROT_W) | (v >> (64 - ROT_W));
    endfunction

endpackage

// ----- hdl/drad_ifs.sv -----
// ----------------------------------------------------------------------------
// drad_ifs
// valid/ready channels of the rolling hash anchor detector
// ----------------------------------------------------------------------------
interface drad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface drad_res_if;
    logic        valid;
    logic        ready;
    logic        window_full;
    logic        is_anchor;
    logic [31:0] window_position;
    logic [63:0] first_hash;
    logic [63:0] second_hash;

    modport source (output valid, output window_full, output is_anchor,
                    output window_position, output first_hash, output second_hash,
                    input ready);
    modport sink (input valid, input window_full, input is_anchor,
                  input window_position, input first_hash, input second_hash,
                  output ready);
endinterface

interface drad_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] mask_bits;

    modport source (output valid, output mask_bits, input ready);
    modport sink (input valid, input mask_bits, output ready);
endinterface

// ----- hdl/drad_window.sv -----
// ----------------------------------------------------------------------------
// drad_window
// window byte memory with slot, fill and position bookkeeping
// ----------------------------------------------------------------------------
module drad_window
    import drad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       stream_start,
    output s1_t        s1
);

    logic [7:0]        win_mem [WINDOW];
    logic [7:0]        old_byte_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] slot_eff;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_eff;
    logic [31:0]       count_reg;
    logic [31:0]       count_next;
    logic [31:0]       count_eff;
    logic              was_full;
    logic [7:0]        byte_reg;
    logic              start_reg;
    logic              use_out_reg;
    logic              full_reg;
    logic [31:0]       position_reg;

    always_comb
    begin
        slot_eff  = stream_start ? '0 : slot_reg;
        fill_eff  = stream_start ? '0 : fill_reg;
        count_eff = stream_start ? '0 : count_reg;
        was_full  = (fill_eff >= FILL_W'(WINDOW));
        fill_next = was_full ? fill_eff : fill_eff + FILL_W'(1);
        count_next = count_eff + 32'd1;
        slot_next = (slot_eff == SLOT_W'(WINDOW - 1)) ? '0 : slot_eff + SLOT_W'(1);
    end

    // read returns the byte leaving the window, then the slot takes the new one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_byte_reg      <= win_mem[slot_eff];
            win_mem[slot_eff] <= data_byte;
            byte_reg          <= data_byte;
            start_reg         <= stream_start;
            use_out_reg       <= was_full;
            full_reg          <= (fill_next >= FILL_W'(WINDOW));
            position_reg      <= count_next - 32'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    assign s1.data_byte = byte_reg;
    assign s1.old_byte  = old_byte_reg;
    assign s1.start     = start_reg;
    assign s1.use_out   = use_out_reg;
    assign s1.full      = full_reg;
    assign s1.position  = position_reg;

endmodule

// ----- hdl/dual_rolling_hash_anchor_detector_top.sv -----
// ----------------------------------------------------------------------------
// dual_rolling_hash_anchor_detector_top
// two buzhash rolling hashes over a byte window with anchor detection
// ----------------------------------------------------------------------------
// channels: in_ch carries one stream byte and a start flag per transfer;
// res_ch returns one result per byte: window full and anchor flags, window
// start position and both 64-bit hashes; cfg_ch writes the anchor mask and
// is always ready; it is to be written only while no result is pending, but
// the block itself does not enforce this. A byte is registered in the window
// stage, then in the result registers. Throughput: one byte per cycle while
// res_ch is not held; the window memory does one read and one write per byte
// at the same slot; the hash rotate/xor loop has no extra pipeline register.
// reset: hashes, fill count, position and slot clear and the anchor mask
// returns to 63; the window memory is not cleared, its stale bytes are
// never used since the fill count gates the outgoing term.
// stall: while res_ch is held, one more byte is still taken into the
// lookup stage, then in_ch.ready drops until the result is transferred.
// ----------------------------------------------------------------------------
module dual_rolling_hash_anchor_detector_top
    import drad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    drad_in_if.sink    in_ch,
    drad_res_if.source res_ch,
    drad_cfg_if.sink   cfg_ch
);

    s1_t         s1;
    logic        accept;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        s1_move;
    logic        out_free;
    logic [63:0] mask_reg;
    logic [63:0] hash_one_reg;
    logic [63:0] hash_two_reg;
    logic [63:0] hash_one_next;
    logic [63:0] hash_two_next;
    logic [63:0] base_one;
    logic [63:0] base_two;
    logic [63:0] out_one;
    logic [63:0] out_two;
    logic        full_reg;
    logic        anchor_reg;
    logic [31:0] position_reg;

    assign out_free    = !out_valid_reg || res_ch.ready;
    assign s1_move     = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || s1_move;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    drad_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (in_ch.data_byte),
        .stream_start (in_ch.stream_start),
        .s1           (s1)
    );

    always_comb
    begin
        base_one = s1.start ? '0 : hash_one_reg;
        base_two = s1.start ? '0 : hash_two_reg;
        out_one  = s1.use_out ? rotl_window(TAB_ONE[s1.old_byte]) : '0;
        out_two  = s1.use_out ? rotl_window(TAB_TWO[s1.old_byte]) : '0;
        hash_one_next = rotl_one(base_one) ^ out_one ^ TAB_ONE[s1.data_byte];
        hash_two_next = rotl_one(base_two) ^ out_two ^ TAB_TWO[s1.data_byte];
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (res_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= MASK_RESET;
            hash_one_reg  <= '0;
            hash_two_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_ch.valid)
            begin
                mask_reg <= cfg_ch.mask_bits;
            end
            if (s1_move)
            begin
                hash_one_reg <= hash_one_next;
                hash_two_reg <= hash_two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            full_reg     <= s1.full;
            anchor_reg   <= s1.full && ((hash_one_next & mask_reg) == '0);
            position_reg <= s1.position;
        end
    end

    assign res_ch.valid           = out_valid_reg;
    assign res_ch.window_full     = full_reg;
    assign res_ch.is_anchor       = anchor_reg;
    assign res_ch.window_position = position_reg;
    assign res_ch.first_hash      = hash_one_reg;
    assign res_ch.second_hash     = hash_two_reg;

endmodule

// ----- hdl/drad_checker.sv -----
// ----------------------------------------------------------------------------
// drad_checker
// port-level checks of the rolling hash anchor detector
// ----------------------------------------------------------------------------
module drad_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        window_full,
    input  logic        is_anchor,
    input  logic [31:0] window_position
);

    // an anchor needs a full window
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!is_anchor || window_full))
        else $error("anchor reported without full window");

    // partial window always starts at the stream start
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !window_full) |-> (window_position == 32'd0))
        else $error("partial window with nonzero position");

    // input never blocked while no result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a transfer in with no result pending is followed by a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !res_valid) |=> ##[0:1] res_valid)
        else $error("accepted byte produced no result");

    // pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped before transfer");

endmodule

bind dual_rolling_hash_anchor_detector_top drad_checker u_drad_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .res_valid       (res_ch.valid),
    .res_ready       (res_ch.ready),
    .window_full     (res_ch.window_full),
    .is_anchor       (res_ch.is_anchor),
    .window_position (res_ch.window_position)
);

// ----- bench/dual_rolling_hash_anchor_detector_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_rolling_hash_anchor_detector_top_tb
// byte stream checker for the dual rolling hash anchor detector
// ----------------------------------------------------------------------------
// A queue of stream bytes feeds a clocked driver. Every byte the block
// accepts is run through a local model of both buzhash rolling hashes, the
// window and the position counter, and the expected result is queued. A
// clocked monitor compares each returned result field by field with the
// oldest expectation. The run opens with a few directed bytes and goes on
// with random streams (mostly full windows, some short runs and stray
// restarts) under several anchor masks, written only while the block is
// idle. Both sides stall at random, with one stretch of full-rate transfers.
// ----------------------------------------------------------------------------
module dual_rolling_hash_anchor_detector_top_tb;
    import drad_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        logic [7:0] data_byte;
        logic       stream_start;
    } stream_byte_t;

    typedef struct {
        logic        window_full;
        logic        is_anchor;
        logic [31:0] window_position;
        logic [63:0] first_hash;
        logic [63:0] second_hash;
    } hash_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;

    drad_in_if  in_ch ();
    drad_res_if res_ch ();
    drad_cfg_if cfg_ch ();

    dual_rolling_hash_anchor_detector_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .res_ch (res_ch),
        .cfg_ch (cfg_ch)
    );

    stream_byte_t byte_queue[$];
    hash_result_t expected_results[$];

    // local copy of the hash state
    logic [63:0] table_one [256];
    logic [63:0] table_two [256];
    logic [7:0]  window_mem [WINDOW];
    logic [63:0] hash_a = '0;
    logic [63:0] hash_b = '0;
    int          fill = 0;
    int          slot = 0;
    logic [31:0] byte_count = '0;
    logic [63:0] mask_model = MASK_RESET;

    int cycle_count = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int bytes_queued = 0;
    int results_checked = 0;
    int full_seen = 0;
    int anchors_seen = 0;
    int mask_settings = 1;

    assign calm = (cycle_count >= 300) && (cycle_count < 700);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rot_left(logic [63:0] v, int n);
        if (n == 0)
            return v;
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] splitmix_out(logic [63:0] z);
        z = (z ^ (z >> 30)) * MIX_MUL_ONE;
        z = (z ^ (z >> 27)) * MIX_MUL_TWO;
        return z ^ (z >> 31);
    endfunction

    function automatic void advance_hashes(logic [7:0] b, logic st);
        logic [63:0]  leave_a;
        logic [63:0]  leave_b;
        hash_result_t r;
        if (st)
        begin
            hash_a = '0;
            hash_b = '0;
            fill = 0;
            byte_count = '0;
            slot = 0;
        end
        leave_a = '0;
        leave_b = '0;
        if (fill >= WINDOW)
        begin
            leave_a = rot_left(table_one[window_mem[slot]], WINDOW % 64);
            leave_b = rot_left(table_two[window_mem[slot]], WINDOW % 64);
        end
        hash_a = rot_left(hash_a, 1) ^ leave_a ^ table_one[b];
        hash_b = rot_left(hash_b, 1) ^ leave_b ^ table_two[b];
        window_mem[slot] = b;
        slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        byte_count = byte_count + 32'd1;
        if (fill < WINDOW)
            fill++;
        r.window_full = (fill >= WINDOW);
        r.is_anchor = r.window_full && ((hash_a & mask_model) == '0);
        r.window_position = byte_count - 32'(fill);
        r.first_hash = hash_a;
        r.second_hash = hash_b;
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin : drive
        stream_byte_t item;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                advance_hashes(in_ch.data_byte, in_ch.stream_start);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 7))
                begin
                    item = byte_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= item.data_byte;
                    in_ch.stream_start <= item.stream_start;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : observe
        hash_result_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no byte outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("window_full", 64'(want.window_full), 64'(res_ch.window_full));
                    check_field("is_anchor", 64'(want.is_anchor), 64'(res_ch.is_anchor));
                    check_field("window_position", 64'(want.window_position),
                                64'(res_ch.window_position));
                    check_field("first_hash", want.first_hash, res_ch.first_hash);
                    check_field("second_hash", want.second_hash, res_ch.second_hash);
                    full_seen += want.window_full;
                    anchors_seen += want.is_anchor;
                end
                results_checked++;
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    task automatic push_byte(logic [7:0] b, logic st);
        stream_byte_t item;
        item.data_byte = b;
        item.stream_start = st;
        byte_queue.push_back(item);
        bytes_queued++;
    endtask

    // mostly long runs from a restart, some short runs, some stray restarts
    task automatic add_random_streams(int count);
        int          made;
        int          run_len;
        logic        flat;
        logic [7:0]  flat_byte;
        logic        st;
        made = 0;
        while (made < count)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, WINDOW - 1)
                                                  : $urandom_range(WINDOW + 1, 150);
            if (run_len > count - made)
                run_len = count - made;
            flat = ($urandom_range(0, 7) == 0);
            flat_byte = 8'($urandom_range(0, 255));
            for (int k = 0; k < run_len; k++)
            begin
                st = (k == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 199) == 0);
                push_byte(flat ? flat_byte : 8'($urandom_range(0, 255)), st);
            end
            made += run_len;
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (results_checked != bytes_queued);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mask(logic [63:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mask_bits <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        mask_model = value;
        mask_settings++;
    endtask

    initial
    begin : stimulus
        logic [63:0] seed_a;
        logic [63:0] seed_b;
        logic [63:0] m;
        logic [63:0] masks[$];

        seed_a = SEED_ONE;
        seed_b = SEED_TWO;
        for (int i = 0; i < 256; i++)
        begin
            seed_a = seed_a + MIX_STEP;
            seed_b = seed_b + MIX_STEP;
            table_one[i] = splitmix_out(seed_a);
            table_two[i] = splitmix_out(seed_b);
        end
        foreach (window_mem[i])
            window_mem[i] = '0;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.stream_start = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.mask_bits = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // bytes straight after reset, no restart
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h55, 1'b0);
        // restart over a stale window
        push_byte(8'hfe, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h0f, 1'b0);
        push_byte(8'hf0, 1'b0);
        add_random_streams(150);
        wait_drained();

        masks.push_back(64'h0);
        masks.push_back({64{1'b1}});
        masks.push_back(64'h1);
        masks.push_back(64'h8000_0000_0000_0000);
        m = '0;
        repeat ($urandom_range(1, 8)) m[$urandom_range(0, 63)] = 1'b1;
        masks.push_back(m);
        masks.push_back({$urandom, $urandom});
        masks.push_back(MASK_RESET);
        foreach (masks[p])
        begin
            write_mask(masks[p]);
            add_random_streams(135);
            wait_drained();
        end

        $display("sent %0d bytes under %0d anchor masks", bytes_sent, mask_settings);
        $display("checked %0d full windows, %0d of them anchors", full_seen, anchors_seen);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
